// File: sv/hill_cipher_2x2_mod26_top_assert.svh
// Assertion macros for the Hill cipher block.
`ifndef HILL_CIPHER_2X2_MOD26_TOP_ASSERT_SVH
`define HILL_CIPHER_2X2_MOD26_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define HC2_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hc2 assertion failed");

// Next-cycle implication.
`define HC2_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hc2 assertion failed");

`else

`define HC2_ASSERT_NOW(label, pre, post)
`define HC2_ASSERT_NEXT(label, pre, post)

`endif

`endif

// File: sv/hc2_pkg.sv
// Shared types, constants and modulo-26 helpers for the Hill cipher block.
package hc2_pkg;

  localparam int MODULUS      = 26;
  localparam int LETTER_W     = 5;
  localparam int PROD_W       = 10;
  localparam int SUM_W        = 11;
  localparam int CHAR_W       = 8;
  localparam int OUT_CHAR_W   = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 5;
  localparam int PIPE_STAGES  = 6;
  localparam int LETTER_DELAY = 4;

  localparam logic [11:0] RECIP26 = 12'd2521;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R0C0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R0C1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R1C0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R1C1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd4;

  localparam logic [LETTER_W-1:0] KEY_R0C0_RST = 5'd9;
  localparam logic [LETTER_W-1:0] KEY_R0C1_RST = 5'd4;
  localparam logic [LETTER_W-1:0] KEY_R1C0_RST = 5'd5;
  localparam logic [LETTER_W-1:0] KEY_R1C1_RST = 5'd7;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [LETTER_W-1:0] m00;
    logic [LETTER_W-1:0] m01;
    logic [LETTER_W-1:0] m10;
    logic [LETTER_W-1:0] m11;
  } hc2_mat_t;

  typedef struct packed {
    logic                ok;
    logic [LETTER_W-1:0] val;
  } hc2_inv_t;

  function automatic logic [LETTER_W-1:0] red26(logic [LETTER_W-1:0] x);
    logic [LETTER_W-1:0] r;
    r = (x >= LETTER_W'(MODULUS)) ? LETTER_W'(x - LETTER_W'(MODULUS)) : x;
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] neg26(logic [LETTER_W-1:0] x);
    logic [LETTER_W-1:0] r;
    r = (x == '0) ? '0 : LETTER_W'(LETTER_W'(MODULUS) - x);
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] mod26(logic [SUM_W-1:0] x);
    logic [22:0]      prod;
    logic [SUM_W-1:0] q;
    logic [SUM_W-1:0] r;
    prod = 23'(x) * 23'(RECIP26);
    q    = SUM_W'(prod[22:16]);
    r    = SUM_W'(x - SUM_W'(q * SUM_W'(MODULUS)));
    if (r >= SUM_W'(MODULUS)) begin
      r = SUM_W'(r - SUM_W'(MODULUS));
    end
    return r[LETTER_W-1:0];
  endfunction

  function automatic hc2_inv_t inv26(logic [LETTER_W-1:0] d);
    hc2_inv_t r;
    r.ok = 1'b1;
    case (d)
      5'd1:    r.val = 5'd1;
      5'd3:    r.val = 5'd9;
      5'd5:    r.val = 5'd21;
      5'd7:    r.val = 5'd15;
      5'd9:    r.val = 5'd3;
      5'd11:   r.val = 5'd19;
      5'd15:   r.val = 5'd7;
      5'd17:   r.val = 5'd23;
      5'd19:   r.val = 5'd11;
      5'd21:   r.val = 5'd5;
      5'd23:   r.val = 5'd17;
      5'd25:   r.val = 5'd25;
      default: begin
        r.ok  = 1'b0;
        r.val = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] letter_value(logic [CHAR_W-1:0] c);
    logic [LETTER_W-1:0] v;
    v = '0;
    if (c inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
      v = LETTER_W'(c - ASCII_UPPER_A);
    end else if (c inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
      v = LETTER_W'(c - ASCII_LOWER_A);
    end
    return v;
  endfunction

endpackage

// File: sv/hill_cipher_2x2_mod26_top.sv
// Top level of the 2x2 Hill cipher: config registers, pipeline control, lanes and output merge.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  in      | in_valid/in_ready  | in_first_char, in_second_char, in_last_block
//  out     | out_valid/out_ready| out_first, out_second, out_key_error, out_last
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  One transaction per cycle while the output is not stalled.
//  Depth is set by the key-inverse pipeline (products, reduce, inverse scale, reduce)
//  followed by two lane stages and the output register.
//  Reset clears valid bits and loads the default key in encrypt mode.
//  A stalled output freezes the whole pipeline; in_ready drops only then.
`include "hill_cipher_2x2_mod26_top_assert.svh"

module hill_cipher_2x2_mod26_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hc2_pkg::CHAR_W-1:0]       in_first_char,
  input  logic [hc2_pkg::CHAR_W-1:0]       in_second_char,
  input  logic                             in_last_block,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hc2_pkg::OUT_CHAR_W-1:0]   out_first,
  output logic [hc2_pkg::OUT_CHAR_W-1:0]   out_second,
  output logic                             out_key_error,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [hc2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hc2_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hc2_pkg::hc2_mat_t                 key_r;
  logic                              dir_r;
  logic                              adv;
  logic [hc2_pkg::PIPE_STAGES-1:0]   vld_r;
  logic                              out_valid_r;
  logic [hc2_pkg::LETTER_W-1:0]      p0_r [hc2_pkg::LETTER_DELAY];
  logic [hc2_pkg::LETTER_W-1:0]      p1_r [hc2_pkg::LETTER_DELAY];
  logic [hc2_pkg::PIPE_STAGES-1:0]   last_r;
  logic                              err5_r;
  logic                              err6_r;
  hc2_pkg::hc2_mat_t                 eff;
  logic                              err4;
  logic [hc2_pkg::LETTER_W-1:0]      c0;
  logic [hc2_pkg::LETTER_W-1:0]      c1;
  logic [hc2_pkg::OUT_CHAR_W-1:0]    first_r;
  logic [hc2_pkg::OUT_CHAR_W-1:0]    second_r;
  logic [hc2_pkg::OUT_CHAR_W-1:0]    first_nxt;
  logic [hc2_pkg::OUT_CHAR_W-1:0]    second_nxt;
  logic                              key_error_r;
  logic                              last_out_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.m00 <= hc2_pkg::KEY_R0C0_RST;
      key_r.m01 <= hc2_pkg::KEY_R0C1_RST;
      key_r.m10 <= hc2_pkg::KEY_R1C0_RST;
      key_r.m11 <= hc2_pkg::KEY_R1C1_RST;
      dir_r     <= hc2_pkg::DIR_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_index)
        hc2_pkg::CFG_KEY_R0C0:  key_r.m00 <= cfg_data;
        hc2_pkg::CFG_KEY_R0C1:  key_r.m01 <= cfg_data;
        hc2_pkg::CFG_KEY_R1C0:  key_r.m10 <= cfg_data;
        hc2_pkg::CFG_KEY_R1C1:  key_r.m11 <= cfg_data;
        hc2_pkg::CFG_DIRECTION: dir_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[hc2_pkg::PIPE_STAGES-2:0], in_valid};
      out_valid_r <= vld_r[hc2_pkg::PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r[0] <= hc2_pkg::letter_value(in_first_char);
      p1_r[0] <= hc2_pkg::letter_value(in_second_char);
      for (int i = 1; i < hc2_pkg::LETTER_DELAY; i++) begin
        p0_r[i] <= p0_r[i-1];
        p1_r[i] <= p1_r[i-1];
      end
      last_r <= {last_r[hc2_pkg::PIPE_STAGES-2:0], in_last_block};
      err5_r <= err4;
      err6_r <= err5_r;
    end
  end

  hc2_keygen u_keygen (
    .clk   (clk),
    .en    (adv),
    .key_i (key_r),
    .dir_i (dir_r),
    .eff_o (eff),
    .err_o (err4)
  );

  hc2_lane u_lane0 (
    .clk  (clk),
    .en   (adv),
    .p0_i (p0_r[hc2_pkg::LETTER_DELAY-1]),
    .p1_i (p1_r[hc2_pkg::LETTER_DELAY-1]),
    .e0_i (eff.m00),
    .e1_i (eff.m10),
    .c_o  (c0)
  );

  hc2_lane u_lane1 (
    .clk  (clk),
    .en   (adv),
    .p0_i (p0_r[hc2_pkg::LETTER_DELAY-1]),
    .p1_i (p1_r[hc2_pkg::LETTER_DELAY-1]),
    .e0_i (eff.m01),
    .e1_i (eff.m11),
    .c_o  (c1)
  );

  assign first_nxt  = err6_r ? '0 :
                      hc2_pkg::OUT_CHAR_W'(c0) + hc2_pkg::ASCII_UPPER_A[hc2_pkg::OUT_CHAR_W-1:0];
  assign second_nxt = err6_r ? '0 :
                      hc2_pkg::OUT_CHAR_W'(c1) + hc2_pkg::ASCII_UPPER_A[hc2_pkg::OUT_CHAR_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      key_error_r <= err6_r;
      last_out_r  <= last_r[hc2_pkg::PIPE_STAGES-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_first     = first_r;
  assign out_second    = second_r;
  assign out_key_error = key_error_r;
  assign out_last      = last_out_r;

  `HC2_ASSERT_NOW(a_err_zeroes, out_valid && out_key_error, out_first == '0 && out_second == '0)
  `HC2_ASSERT_NOW(a_letter_range, out_valid && !out_key_error, out_first >= 7'd65 && out_first <= 7'd90 && out_second >= 7'd65 && out_second <= 7'd90)
  `HC2_ASSERT_NEXT(a_enter_pipe, in_valid && in_ready, vld_r[0])
  `HC2_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_r) && out_valid_r)

endmodule

// File: sv/hc2_keygen.sv
// Effective key pipeline: key reduced modulo 26 for encrypt, modular inverse key for decrypt.
module hc2_keygen (
  input  logic             clk,
  input  logic             en,
  input  hc2_pkg::hc2_mat_t key_i,
  input  logic             dir_i,
  output hc2_pkg::hc2_mat_t eff_o,
  output logic             err_o
);

  hc2_pkg::hc2_mat_t                red;
  hc2_pkg::hc2_mat_t                k1_mat_r;
  hc2_pkg::hc2_mat_t                k2_mat_r;
  hc2_pkg::hc2_mat_t                k3_mat_r;
  hc2_pkg::hc2_mat_t                eff_r;
  hc2_pkg::hc2_mat_t                eff_nxt;
  logic [hc2_pkg::PROD_W-1:0]       ad_r;
  logic [hc2_pkg::PROD_W-1:0]       bc_r;
  logic [hc2_pkg::LETTER_W-1:0]     det_r;
  logic [hc2_pkg::LETTER_W-1:0]     det_nxt;
  logic [hc2_pkg::PROD_W-1:0]       p00_r;
  logic [hc2_pkg::PROD_W-1:0]       p01_r;
  logic [hc2_pkg::PROD_W-1:0]       p10_r;
  logic [hc2_pkg::PROD_W-1:0]       p11_r;
  logic                             k1_dir_r;
  logic                             k2_dir_r;
  logic                             k3_dir_r;
  logic                             k3_err_r;
  logic                             err_r;
  hc2_pkg::hc2_inv_t                inv;

  always_comb begin
    red.m00 = hc2_pkg::red26(key_i.m00);
    red.m01 = hc2_pkg::red26(key_i.m01);
    red.m10 = hc2_pkg::red26(key_i.m10);
    red.m11 = hc2_pkg::red26(key_i.m11);
  end

  assign det_nxt = hc2_pkg::mod26(hc2_pkg::SUM_W'(ad_r) + hc2_pkg::SUM_W'(650)
                                  - hc2_pkg::SUM_W'(bc_r));
  assign inv     = hc2_pkg::inv26(det_r);

  always_comb begin
    if (k3_dir_r == hc2_pkg::DIR_DECRYPT) begin
      eff_nxt.m00 = hc2_pkg::mod26(hc2_pkg::SUM_W'(p00_r));
      eff_nxt.m01 = hc2_pkg::mod26(hc2_pkg::SUM_W'(p01_r));
      eff_nxt.m10 = hc2_pkg::mod26(hc2_pkg::SUM_W'(p10_r));
      eff_nxt.m11 = hc2_pkg::mod26(hc2_pkg::SUM_W'(p11_r));
    end else begin
      eff_nxt = k3_mat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r     <= hc2_pkg::PROD_W'(red.m00 * red.m11);
      bc_r     <= hc2_pkg::PROD_W'(red.m01 * red.m10);
      k1_mat_r <= red;
      k1_dir_r <= dir_i;

      det_r    <= det_nxt;
      k2_mat_r <= k1_mat_r;
      k2_dir_r <= k1_dir_r;

      p00_r    <= hc2_pkg::PROD_W'(k2_mat_r.m11 * inv.val);
      p01_r    <= hc2_pkg::PROD_W'(hc2_pkg::neg26(k2_mat_r.m01) * inv.val);
      p10_r    <= hc2_pkg::PROD_W'(hc2_pkg::neg26(k2_mat_r.m10) * inv.val);
      p11_r    <= hc2_pkg::PROD_W'(k2_mat_r.m00 * inv.val);
      k3_mat_r <= k2_mat_r;
      k3_dir_r <= k2_dir_r;
      k3_err_r <= (k2_dir_r == hc2_pkg::DIR_DECRYPT) && !inv.ok;

      eff_r    <= eff_nxt;
      err_r    <= k3_err_r;
    end
  end

  assign eff_o = eff_r;
  assign err_o = err_r;

endmodule

// File: sv/hc2_lane.sv
// One output column: dot product of the letter pair with a key column, modulo 26.
module hc2_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hc2_pkg::LETTER_W-1:0] p0_i,
  input  logic [hc2_pkg::LETTER_W-1:0] p1_i,
  input  logic [hc2_pkg::LETTER_W-1:0] e0_i,
  input  logic [hc2_pkg::LETTER_W-1:0] e1_i,
  output logic [hc2_pkg::LETTER_W-1:0] c_o
);

  logic [hc2_pkg::PROD_W-1:0]   prod0_r;
  logic [hc2_pkg::PROD_W-1:0]   prod1_r;
  logic [hc2_pkg::LETTER_W-1:0] c_r;
  logic [hc2_pkg::LETTER_W-1:0] c_nxt;

  assign c_nxt = hc2_pkg::mod26(hc2_pkg::SUM_W'(prod0_r) + hc2_pkg::SUM_W'(prod1_r));

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= hc2_pkg::PROD_W'(p0_i * e0_i);
      prod1_r <= hc2_pkg::PROD_W'(p1_i * e1_i);
      c_r     <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule

// File: bench/tb_hill_cipher_2x2_mod26_top.sv
// Self-checking testbench for the 2x2 Hill cipher block: directed, random and backpressure tests.
module tb_hill_cipher_2x2_mod26_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = hc2_pkg::PIPE_STAGES + 4;
  localparam int STALL_CYCLES   = 300;

  typedef struct packed {
    logic [hc2_pkg::OUT_CHAR_W-1:0] first;
    logic [hc2_pkg::OUT_CHAR_W-1:0] second;
    logic                           err;
    logic                           last;
  } cipher_out_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [hc2_pkg::CHAR_W-1:0]     in_first_char;
  logic [hc2_pkg::CHAR_W-1:0]     in_second_char;
  logic                           in_last_block;
  logic                           out_valid;
  logic                           out_ready;
  logic [hc2_pkg::OUT_CHAR_W-1:0] out_first;
  logic [hc2_pkg::OUT_CHAR_W-1:0] out_second;
  logic                           out_key_error;
  logic                           out_last;
  logic                           cfg_we;
  logic [hc2_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hc2_pkg::CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the key registers and mode.
  logic [hc2_pkg::LETTER_W-1:0] key_m00;
  logic [hc2_pkg::LETTER_W-1:0] key_m01;
  logic [hc2_pkg::LETTER_W-1:0] key_m10;
  logic [hc2_pkg::LETTER_W-1:0] key_m11;
  logic                         key_dir;

  cipher_out_t expected_blocks_q[$];
  int          error_count;
  int          idle_cycles;
  logic        steady;
  logic        stall_go;

  hill_cipher_2x2_mod26_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_char  (in_first_char),
    .in_second_char (in_second_char),
    .in_last_block  (in_last_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_first      (out_first),
    .out_second     (out_second),
    .out_key_error  (out_key_error),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int plain_index(input logic [hc2_pkg::CHAR_W-1:0] c);
    logic [hc2_pkg::CHAR_W-1:0] u;
    u = c;
    if (u >= hc2_pkg::ASCII_LOWER_A && u <= hc2_pkg::ASCII_LOWER_Z) begin
      u = u - (hc2_pkg::ASCII_LOWER_A - hc2_pkg::ASCII_UPPER_A);
    end
    if (u >= hc2_pkg::ASCII_UPPER_A && u <= hc2_pkg::ASCII_UPPER_Z) begin
      return int'(u - hc2_pkg::ASCII_UPPER_A);
    end
    return 0;
  endfunction

  function automatic cipher_out_t hill_predict(input logic [hc2_pkg::CHAR_W-1:0] c0,
                                               input logic [hc2_pkg::CHAR_W-1:0] c1,
                                               input logic last);
    cipher_out_t r;
    int p0, p1, m00, m01, m10, m11, det, inv, a00, a01, a10, a11, y0, y1;
    p0     = plain_index(c0);
    p1     = plain_index(c1);
    m00    = int'(key_m00);
    m01    = int'(key_m01);
    m10    = int'(key_m10);
    m11    = int'(key_m11);
    r.last = last;
    r.err  = 1'b0;
    if (key_dir == hc2_pkg::DIR_DECRYPT) begin
      det = (m00 * m11 + hc2_pkg::MODULUS * 40 - m01 * m10) % hc2_pkg::MODULUS;
      inv = 0;
      for (int x = 1; x < hc2_pkg::MODULUS; x++) begin
        if (inv == 0 && (det * x) % hc2_pkg::MODULUS == 1) inv = x;
      end
      if (inv == 0) begin
        r.first  = '0;
        r.second = '0;
        r.err    = 1'b1;
        return r;
      end
      a00 = ((m11 % hc2_pkg::MODULUS) * inv) % hc2_pkg::MODULUS;
      a01 = (((hc2_pkg::MODULUS - m01 % hc2_pkg::MODULUS) % hc2_pkg::MODULUS) * inv)
            % hc2_pkg::MODULUS;
      a10 = (((hc2_pkg::MODULUS - m10 % hc2_pkg::MODULUS) % hc2_pkg::MODULUS) * inv)
            % hc2_pkg::MODULUS;
      a11 = ((m00 % hc2_pkg::MODULUS) * inv) % hc2_pkg::MODULUS;
      m00 = a00;
      m01 = a01;
      m10 = a10;
      m11 = a11;
    end
    y0       = (p0 * m00 + p1 * m10) % hc2_pkg::MODULUS;
    y1       = (p0 * m01 + p1 * m11) % hc2_pkg::MODULUS;
    r.first  = hc2_pkg::OUT_CHAR_W'(y0 + int'(hc2_pkg::ASCII_UPPER_A));
    r.second = hc2_pkg::OUT_CHAR_W'(y1 + int'(hc2_pkg::ASCII_UPPER_A));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic write_reg(input logic [hc2_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hc2_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      hc2_pkg::CFG_KEY_R0C0:  key_m00 = val;
      hc2_pkg::CFG_KEY_R0C1:  key_m01 = val;
      hc2_pkg::CFG_KEY_R1C0:  key_m10 = val;
      hc2_pkg::CFG_KEY_R1C1:  key_m11 = val;
      hc2_pkg::CFG_DIRECTION: key_dir = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input int a, input int b, input int c, input int d, input logic dir);
    write_reg(hc2_pkg::CFG_KEY_R0C0, hc2_pkg::CFG_DATA_W'(a));
    write_reg(hc2_pkg::CFG_KEY_R0C1, hc2_pkg::CFG_DATA_W'(b));
    write_reg(hc2_pkg::CFG_KEY_R1C0, hc2_pkg::CFG_DATA_W'(c));
    write_reg(hc2_pkg::CFG_KEY_R1C1, hc2_pkg::CFG_DATA_W'(d));
    write_reg(hc2_pkg::CFG_DIRECTION, hc2_pkg::CFG_DATA_W'(dir));
  endtask

  task automatic send_block(input logic [hc2_pkg::CHAR_W-1:0] c0,
                            input logic [hc2_pkg::CHAR_W-1:0] c1,
                            input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_first_char  <= c0;
    in_second_char <= c1;
    in_last_block  <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_blocks_q.push_back(hill_predict(c0, c1, last));
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_blocks_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [hc2_pkg::CHAR_W-1:0] rand_text_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return hc2_pkg::ASCII_UPPER_A + hc2_pkg::CHAR_W'($urandom_range(0, 25));
    if (sel < 85) return hc2_pkg::ASCII_LOWER_A + hc2_pkg::CHAR_W'($urandom_range(0, 25));
    return hc2_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic int rand_key_entry();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(26, 31));
    return int'($urandom_range(0, 25));
  endfunction

  // One message: blocks of text, a padded short tail now and then, last mostly on the final block.
  task automatic send_message(inout int sent);
    int                         len;
    logic                       last;
    logic [hc2_pkg::CHAR_W-1:0] c1;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if ($urandom_range(0, 99) < 15) last = 1'($urandom_range(0, 1));
      c1 = rand_text_byte();
      if (i == len - 1 && $urandom_range(0, 3) == 0) begin
        c1 = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'h00;
      end
      send_block(rand_text_byte(), c1, last);
      sent++;
    end
  endtask

  task automatic test_reset_key_encrypt();
    send_block(hc2_pkg::ASCII_UPPER_A, hc2_pkg::ASCII_UPPER_Z, 1'b0);
    send_block(hc2_pkg::ASCII_LOWER_A, hc2_pkg::ASCII_LOWER_Z, 1'b0);
    send_block(8'h00, 8'hFF, 1'b0);
    send_block(8'h40, 8'h5B, 1'b0);
    send_block(8'h60, 8'h7B, 1'b0);
    send_block(8'h48, 8'h69, 1'b0);
    send_block(8'h71, 8'h20, 1'b1);
    wait_drain();
  endtask

  task automatic test_reset_key_decrypt();
    write_reg(hc2_pkg::CFG_DIRECTION, hc2_pkg::CFG_DATA_W'(hc2_pkg::DIR_DECRYPT));
    send_block(hc2_pkg::ASCII_UPPER_Z, hc2_pkg::ASCII_UPPER_A, 1'b0);
    send_block(8'h6D, 8'h4B, 1'b0);
    send_block(8'h80, 8'h2E, 1'b1);
    wait_drain();
  endtask

  task automatic test_singular_key();
    load_key(2, 4, 1, 2, hc2_pkg::DIR_DECRYPT);
    send_block(8'h48, 8'h49, 1'b0);
    send_block(8'h68, 8'h00, 1'b1);
    wait_drain();
    load_key(1, 0, 0, 13, hc2_pkg::DIR_DECRYPT);
    send_block(hc2_pkg::ASCII_UPPER_Z, hc2_pkg::ASCII_LOWER_Z, 1'b1);
    wait_drain();
    write_reg(hc2_pkg::CFG_DIRECTION, hc2_pkg::CFG_DATA_W'(hc2_pkg::DIR_ENCRYPT));
    send_block(8'h48, 8'h49, 1'b0);
    send_block(hc2_pkg::ASCII_UPPER_Z, hc2_pkg::ASCII_UPPER_Z, 1'b1);
    wait_drain();
  endtask

  task automatic test_key_extremes();
    load_key(0, 0, 0, 0, hc2_pkg::DIR_ENCRYPT);
    send_block(hc2_pkg::ASCII_UPPER_Z, hc2_pkg::ASCII_UPPER_Z, 1'b1);
    wait_drain();
    load_key(25, 0, 0, 25, hc2_pkg::DIR_DECRYPT);
    send_block(hc2_pkg::ASCII_UPPER_Z, 8'h42, 1'b0);
    wait_drain();
    load_key(27, 26, 29, 31, hc2_pkg::DIR_DECRYPT);
    send_block(8'h51, 8'h77, 1'b0);
    wait_drain();
    write_reg(hc2_pkg::CFG_DIRECTION, hc2_pkg::CFG_DATA_W'(hc2_pkg::DIR_ENCRYPT));
    send_block(8'h51, 8'h77, 1'b1);
    wait_drain();
    // Unused indexes must leave the key alone.
    write_reg(3'd5, 5'd3);
    write_reg(3'd6, 5'd31);
    write_reg(3'd7, 5'd17);
    send_block(8'h4B, 8'h45, 1'b0);
    wait_drain();
    // Only bit 0 of the data selects the mode.
    write_reg(hc2_pkg::CFG_DIRECTION, 5'b11110);
    send_block(8'h59, 8'h6F, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int sent;
    for (int p = 0; p < 12; p++) begin
      if (p == 0) begin
        load_key(31, 31, 31, 31, hc2_pkg::DIR_DECRYPT);
      end else if (p == 1) begin
        load_key(3, 3, 2, 5, hc2_pkg::DIR_DECRYPT);
      end else begin
        load_key(rand_key_entry(), rand_key_entry(), rand_key_entry(), rand_key_entry(),
                 1'($urandom_range(0, 1)));
      end
      steady = (p == 4);
      sent   = 0;
      while (sent < 150) send_message(sent);
      wait_drain();
      steady = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    int sent;
    load_key(rand_key_entry(), rand_key_entry(), rand_key_entry(), rand_key_entry(),
             1'($urandom_range(0, 1)));
    sent = 0;
    while (sent < 20) send_message(sent);
    stall_go = 1'b1;
    while (sent < 200) send_message(sent);
    wait_drain();
  endtask

  // Receiver: random ready (always ready while steady), with one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_go) begin
        stall_go = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_blocks_q.size() == 0) begin
        report_mismatch("unexpected result, out_first", int'(out_first), -1);
      end else begin
        want = expected_blocks_q.pop_front();
        if (out_first !== want.first) begin
          report_mismatch("out_first", int'(out_first), int'(want.first));
        end
        if (out_second !== want.second) begin
          report_mismatch("out_second", int'(out_second), int'(want.second));
        end
        if (out_key_error !== want.err) begin
          report_mismatch("out_key_error", int'(out_key_error), int'(want.err));
        end
        if (out_last !== want.last) begin
          report_mismatch("out_last", int'(out_last), int'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hill_cipher_2x2_mod26_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_first_char  = '0;
    in_second_char = '0;
    in_last_block  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    error_count    = 0;
    idle_cycles    = 0;
    steady         = 1'b0;
    stall_go       = 1'b0;
    key_m00        = hc2_pkg::KEY_R0C0_RST;
    key_m01        = hc2_pkg::KEY_R0C1_RST;
    key_m10        = hc2_pkg::KEY_R1C0_RST;
    key_m11        = hc2_pkg::KEY_R1C1_RST;
    key_dir        = hc2_pkg::DIR_ENCRYPT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_reset_key_encrypt();
    test_reset_key_decrypt();
    test_singular_key();
    test_key_extremes();
    test_random_traffic();
    test_backpressure();

    if (error_count == 0 && expected_blocks_q.size() == 0) begin
      $display("hill_cipher_2x2_mod26_top regression: pass");
    end else begin
      $display("hill_cipher_2x2_mod26_top regression: fail");
    end
    $finish;
  end

endmodule
